// ===== hw/rtl/rbs_pkg.sv =====
package rbs_pkg;

   // number format and datapath widths
   localparam int FRAC_BITS = 16;
   localparam int DW        = 32;
   localparam int NUM_W     = DW + 1 + FRAC_BITS;   // scaled |bound - origin|
   localparam int REM_IN_W  = NUM_W - DW;           // numerator bits above the quotient
   localparam int N_AXES    = 3;
   localparam int N_LANES   = 2 * N_AXES;
   localparam int N_STEPS   = DW;                   // one quotient bit per cell
   localparam int N_STAGES  = N_STEPS + 3;          // front, cells, two back stages
   localparam int CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION_Z = 3'd5;

   localparam logic signed [DW-1:0] T_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] T_MIN = {1'b1, {(DW-1){1'b0}}};

   typedef struct packed {
      logic [N_AXES-1:0][DW-1:0] origin;
      logic [N_AXES-1:0][DW-1:0] direction;
   } ray_type;

   // one division in flight: partial remainder, numerator bits / quotient bits
   typedef struct packed {
      logic [DW:0]   rem;
      logic [DW-1:0] work;
      logic          neg;
      logic          ovf;
   } lane_type;

   typedef struct packed {
      lane_type [N_LANES-1:0] lane;
      logic [DW-1:0]          t_lo;
      logic [DW-1:0]          t_hi;
      logic [N_AXES-1:0]      zdir;
      logic                   zpass;
   } pipe_type;

endpackage

// ===== hw/rtl/rbs_req_if.sv =====
interface rbs_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] box_lo_x;
   logic [31:0] box_hi_x;
   logic [31:0] box_lo_y;
   logic [31:0] box_hi_y;
   logic [31:0] box_lo_z;
   logic [31:0] box_hi_z;
   logic [31:0] t_lo;
   logic [31:0] t_hi;

   modport source (output valid, box_lo_x, box_hi_x, box_lo_y, box_hi_y, box_lo_z, box_hi_z,
                   t_lo, t_hi, input ready);
   modport sink   (input valid, box_lo_x, box_hi_x, box_lo_y, box_hi_y, box_lo_z, box_hi_z,
                   t_lo, t_hi, output ready);
endinterface

// ===== hw/rtl/rbs_rsp_if.sv =====
interface rbs_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink   (input valid, hit, output ready);
endinterface

// ===== hw/rtl/rbs_front.sv =====
module rbs_front (
   input  logic                                          clock,
   input  logic                                          en,
   input  rbs_pkg::ray_type                              ray,
   input  logic [rbs_pkg::N_AXES-1:0][rbs_pkg::DW-1:0]   dmag,
   input  logic [rbs_pkg::N_LANES-1:0][rbs_pkg::DW-1:0]  bound,
   input  logic [rbs_pkg::DW-1:0]                        t_lo,
   input  logic [rbs_pkg::DW-1:0]                        t_hi,
   output rbs_pkg::pipe_type                             out_ff
);
   import rbs_pkg::*;

   pipe_type out_in;

   // form scaled numerators, signs and overflow flags; check zero-direction slabs
   always_comb begin
      logic signed [DW:0]   diff;
      logic [DW:0]          mag;
      logic [NUM_W-1:0]     num;
      logic signed [DW-1:0] org;
      logic signed [DW-1:0] blo;
      logic signed [DW-1:0] bhi;
      logic signed [DW-1:0] smin;
      logic signed [DW-1:0] smax;
      out_in       = '0;
      out_in.t_lo  = t_lo;
      out_in.t_hi  = t_hi;
      out_in.zpass = 1'b1;
      for (int l = 0; l < N_LANES; l++) begin
         org  = $signed(ray.origin[l/2]);
         diff = $signed({bound[l][DW-1], bound[l]}) - $signed({org[DW-1], org});
         mag  = diff[DW] ? (~diff + 1'b1) : diff;
         num  = {mag, {FRAC_BITS{1'b0}}};
         out_in.lane[l].neg  = diff[DW] ^ ray.direction[l/2][DW-1];
         out_in.lane[l].ovf  = {{(DW-REM_IN_W){1'b0}}, num[NUM_W-1:DW]} >= dmag[l/2];
         out_in.lane[l].rem  = {{(DW+1-REM_IN_W){1'b0}}, num[NUM_W-1:DW]};
         out_in.lane[l].work = num[DW-1:0];
      end
      for (int a = 0; a < N_AXES; a++) begin
         org  = $signed(ray.origin[a]);
         blo  = $signed(bound[2*a]);
         bhi  = $signed(bound[2*a+1]);
         smin = (blo < bhi) ? blo : bhi;
         smax = (blo < bhi) ? bhi : blo;
         out_in.zdir[a] = (ray.direction[a] == '0);
         if (out_in.zdir[a] && (org < smin || org > smax)) begin
            out_in.zpass = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end
endmodule

// ===== hw/rtl/rbs_div_cell.sv =====
module rbs_div_cell (
   input  logic                                        clock,
   input  logic                                        en,
   input  logic [rbs_pkg::N_AXES-1:0][rbs_pkg::DW-1:0] dmag,
   input  rbs_pkg::pipe_type                           in_data,
   output rbs_pkg::pipe_type                           out_ff
);
   import rbs_pkg::*;

   pipe_type out_in;

   // one restoring-division step on every lane: shift in a numerator bit, try subtract
   always_comb begin
      logic [DW:0] r2;
      logic        ge;
      out_in = in_data;
      for (int l = 0; l < N_LANES; l++) begin
         r2 = {in_data.lane[l].rem[DW-1:0], in_data.lane[l].work[DW-1]};
         ge = r2 >= {1'b0, dmag[l/2]};
         out_in.lane[l].rem  = ge ? (r2 - {1'b0, dmag[l/2]}) : r2;
         out_in.lane[l].work = {in_data.lane[l].work[DW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end
endmodule

// ===== hw/rtl/rbs_back.sv =====
module rbs_back (
   input  logic              clock,
   input  logic              en,
   input  rbs_pkg::pipe_type in_data,
   output logic              hit_ff
);
   import rbs_pkg::*;

   logic [N_LANES-1:0][DW-1:0] t_ff;
   logic [N_LANES-1:0][DW-1:0] t_in;
   logic [DW-1:0]              t_lo_ff;
   logic [DW-1:0]              t_hi_ff;
   logic [N_AXES-1:0]          zdir_ff;
   logic                       zpass_ff;
   logic                       hit_in;

   // apply sign and saturate each quotient
   always_comb begin
      logic [DW-1:0] q;
      for (int l = 0; l < N_LANES; l++) begin
         q = in_data.lane[l].work;
         if (!in_data.lane[l].neg) begin
            t_in[l] = (in_data.lane[l].ovf || q[DW-1]) ? T_MAX : q;
         end else if (in_data.lane[l].ovf || q > T_MIN) begin
            t_in[l] = T_MIN;
         end else begin
            t_in[l] = ~q + 1'b1;
         end
      end
   end

   // order slab distances, clip the interval and decide
   always_comb begin
      logic signed [DW-1:0] t0;
      logic signed [DW-1:0] t1;
      logic signed [DW-1:0] nearv;
      logic signed [DW-1:0] farv;
      logic signed [DW-1:0] start;
      logic signed [DW-1:0] stop;
      start = $signed(t_lo_ff);
      stop  = $signed(t_hi_ff);
      for (int a = 0; a < N_AXES; a++) begin
         t0    = $signed(t_ff[2*a]);
         t1    = $signed(t_ff[2*a+1]);
         nearv = (t0 < t1) ? t0 : t1;
         farv  = (t0 < t1) ? t1 : t0;
         if (!zdir_ff[a]) begin
            if (nearv > start) begin
               start = nearv;
            end
            if (farv < stop) begin
               stop = farv;
            end
         end
      end
      hit_in = zpass_ff && (stop > start);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff     <= t_in;
         t_lo_ff  <= in_data.t_lo;
         t_hi_ff  <= in_data.t_hi;
         zdir_ff  <= in_data.zdir;
         zpass_ff <= in_data.zpass;
         hit_ff   <= hit_in;
      end
   end
endmodule

// ===== hw/rtl/ray_box_slab_test.sv =====
// channel | dir | handshake   | payload
// req     | in  | valid/ready | box_lo/hi_x/y/z, t_lo, t_hi (signed Q16.16)
// rsp     | out | valid/ready | hit
// csr     | in  | csr_we      | csr_index, csr_wdata
//
// One item per cycle while the response is not held; after acceptance an item
// passes through 35 register stages: front stage, 32 division cells one quotient
// bit each, saturate stage, clip-and-compare stage.
// The six slab divisions run side by side down the chain of cells.
// Synchronous reset clears the valid bits and the ray registers to zero.
// A stalled response freezes the whole chain; req ready drops only then.
module ray_box_slab_test (
   input  logic                            clock,
   input  logic                            reset,
   rbs_req_if.sink                         req_chan,
   rbs_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [rbs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rbs_pkg::DW-1:0]          csr_wdata
);
   import rbs_pkg::*;

   ray_type                    ray_ff;
   logic [N_AXES-1:0][DW-1:0]  dmag;
   logic [N_STAGES-1:0]        valid_ff;
   logic                       advance;
   logic [N_LANES-1:0][DW-1:0] bound;
   pipe_type                   chain [0:N_STEPS];

   // ray registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ray_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN_X:    ray_ff.origin[0]    <= csr_wdata;
            CSR_ORIGIN_Y:    ray_ff.origin[1]    <= csr_wdata;
            CSR_ORIGIN_Z:    ray_ff.origin[2]    <= csr_wdata;
            CSR_DIRECTION_X: ray_ff.direction[0] <= csr_wdata;
            CSR_DIRECTION_Y: ray_ff.direction[1] <= csr_wdata;
            CSR_DIRECTION_Z: ray_ff.direction[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // divisor magnitudes
   always_comb begin
      for (int a = 0; a < N_AXES; a++) begin
         dmag[a] = ray_ff.direction[a][DW-1] ? (~ray_ff.direction[a] + 1'b1)
                                             : ray_ff.direction[a];
      end
   end

   // move the whole chain unless the response is held
   assign advance        = !valid_ff[N_STAGES-1] || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign rsp_chan.valid = valid_ff[N_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[N_STAGES-2:0], req_chan.valid};
      end
   end

   assign bound = {req_chan.box_hi_z, req_chan.box_lo_z, req_chan.box_hi_y,
                   req_chan.box_lo_y, req_chan.box_hi_x, req_chan.box_lo_x};

   rbs_front u_front (
      .clock  (clock),
      .en     (advance),
      .ray    (ray_ff),
      .dmag   (dmag),
      .bound  (bound),
      .t_lo   (req_chan.t_lo),
      .t_hi   (req_chan.t_hi),
      .out_ff (chain[0])
   );

   for (genvar i = 0; i < N_STEPS; i++) begin : g_cell
      rbs_div_cell u_cell (
         .clock   (clock),
         .en      (advance),
         .dmag    (dmag),
         .in_data (chain[i]),
         .out_ff  (chain[i+1])
      );
   end

   rbs_back u_back (
      .clock   (clock),
      .en      (advance),
      .in_data (chain[N_STEPS]),
      .hit_ff  (rsp_chan.hit)
   );

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("response valid after reset");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("chain moved during stall");
   a_accept_enter: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> valid_ff[0])
      else $error("accepted item not in front stage");
`endif
endmodule
